// File: sv/modbus_tcp_coil_server_defines.svh
// ---------------------------------------------------------------------------
// Modbus TCP coil server assertion macros
// Assertion forms for the coil server modules, used by the request queue.
// ---------------------------------------------------------------------------
`ifndef MODBUS_TCP_COIL_SERVER_DEFINES_SVH
`define MODBUS_TCP_COIL_SERVER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define MSC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define MSC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/msc_pkg.sv
// ---------------------------------------------------------------------------
// Coil server package
// Function codes, exception codes, frame types shared by the server modules.
// ---------------------------------------------------------------------------
package msc_pkg;

  localparam int MAX_COILS   = 64;
  localparam int FRAME_KEEP  = 21;
  localparam int RESP_MAX    = 17;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0]  FC_READ    = 8'h01;
  localparam logic [7:0]  FC_WSINGLE = 8'h05;
  localparam logic [7:0]  FC_WMULTI  = 8'h0F;
  localparam logic [7:0]  EX_FUNC    = 8'h01;
  localparam logic [7:0]  EX_ADDR    = 8'h02;
  localparam logic [7:0]  EX_VALUE   = 8'h03;
  localparam logic [7:0]  EXC_FLAG   = 8'h80;
  localparam logic [15:0] COIL_ON    = 16'hFF00;

  localparam logic [1:0]  CFG_SERVER_ID  = 2'd0;
  localparam logic [1:0]  CFG_COIL_COUNT = 2'd1;
  localparam logic [1:0]  CFG_COIL_START = 2'd2;

  typedef logic [FRAME_KEEP-1:0][7:0] frame_t;

  // one accepted request frame, bytes 0..20 and saturated frame size
  typedef struct packed {
    frame_t     bytes;
    logic [4:0] fsize;
  } job_t;

  // coil count update toward the coil table
  typedef struct packed {
    logic       en;
    logic [6:0] count;
  } cnt_wr_t;

endpackage

// File: sv/msc_front.sv
// ---------------------------------------------------------------------------
// Coil server front end
// Frames the request byte stream by the MBAP length and filters frames.
// ---------------------------------------------------------------------------
module msc_front import msc_pkg::*; #(
  parameter int RX_LIMIT = 4096
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] rx_byte
  input  logic [7:0] server_id,
  input  logic       q_full,
  output logic       push,
  output job_t       push_job
);

  localparam int HW = $clog2(RX_LIMIT + 2);

  frame_t        store_r, store_nxt;
  logic [HW-1:0] held_r, held_nxt;
  logic [15:0]   dlen_r, dlen_nxt;
  logic [HW:0]   held_inc;
  logic          acc, done, ovf, match;

  assign in_tready = !q_full;
  assign acc       = in_tvalid && in_tready;
  assign held_inc  = {1'b0, held_r} + (HW+1)'(1);

  // store byte, track length, detect end of frame
  always_comb begin
    store_nxt = store_r;
    dlen_nxt  = dlen_r;
    if (held_r < HW'(FRAME_KEEP)) store_nxt[held_r[4:0]] = in_tdata;
    if (held_r == HW'(4)) dlen_nxt = {in_tdata, dlen_r[7:0]};
    else if (held_r == HW'(5)) dlen_nxt = {dlen_r[15:8], in_tdata};
    done  = (held_inc >= (HW+1)'(7)) && (dlen_nxt >= 16'd2) &&
            (17'(held_inc) == 17'(dlen_nxt) + 17'd6);
    ovf   = held_inc > (HW+1)'(RX_LIMIT);
    match = (store_nxt[2] == 8'h00) && (store_nxt[3] == 8'h00) &&
            (store_nxt[6] == server_id);
    held_nxt = held_r;
    if (acc) held_nxt = (done || ovf) ? '0 : held_inc[HW-1:0];
  end

  assign push           = acc && done && match;
  assign push_job.bytes = store_nxt;
  assign push_job.fsize = (held_inc > (HW+1)'(31)) ? 5'd31 : held_inc[4:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      dlen_r <= '0;
    end else if (acc) begin
      held_r <= held_nxt;
      dlen_r <= dlen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) store_r <= store_nxt;
  end

endmodule

// File: sv/msc_queue.sv
// ---------------------------------------------------------------------------
// Coil server request queue
// Two-entry queue of framed requests between front end and back end.
// ---------------------------------------------------------------------------
`include "modbus_tcp_coil_server_defines.svh"
module msc_queue import msc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic head_valid,
  output job_t head
);

  job_t       ent_r [QUEUE_DEPTH];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full       = cnt_r == 2'(QUEUE_DEPTH);
  assign head_valid = cnt_r != 2'd0;
  assign head       = ent_r[rp_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= push_job;
  end

  `MSC_ASSERT_IMP(a_no_overflow, push, !full || pop, "push into full queue")
  `MSC_ASSERT_IMP(a_no_underflow, pop, head_valid, "pop from empty queue")
  `MSC_ASSERT_NXT(a_fill_up, push && !pop && !full, cnt_r == $past(cnt_r) + 2'd1,
    "fill count did not advance on push")

endmodule

// File: sv/msc_back.sv
// ---------------------------------------------------------------------------
// Coil server back end
// Serves one framed request: coil update and response byte streaming.
// ---------------------------------------------------------------------------
module msc_back import msc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        head_valid,
  input  job_t        head,
  output logic        pop,
  input  logic [6:0]  coil_count,
  input  logic [15:0] coil_start,
  input  cnt_wr_t     cnt_wr,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [7:0] tx_byte, [71:8] coil_bits
  output logic        out_tlast   // tx_last
);

  logic [RESP_MAX-1:0][7:0] sh_r, sh_nxt, resp;
  logic [4:0]               cnt_r, cnt_nxt, resp_n;
  logic [63:0]              coil_r, coil_nxt;

  frame_t      b;
  logic [7:0]  fc, bc, code;
  logic [15:0] st, q, i0, iend;
  logic [16:0] q7sum;
  logic [13:0] need;
  logic [3:0]  bcr;
  logic [63:0] qm, wmask, rdata, bitmap, wbits, cmask;
  logic        a_ok, e_ok, q_ok, bc_ok, len_ok, exc, do_rd, do_w5, do_wf, taken;

  assign taken = out_tvalid && out_tready;
  assign pop   = head_valid && ((cnt_r == 5'd0) || ((cnt_r == 5'd1) && out_tready));

  // request fields and window checks
  always_comb begin
    b      = head.bytes;
    fc     = b[7];
    st     = {b[8], b[9]};
    q      = {b[10], b[11]};
    bc     = b[12];
    i0     = st - coil_start;
    iend   = i0 + q - 16'd1;
    a_ok   = i0 < {9'd0, coil_count};
    e_ok   = iend < {9'd0, coil_count};
    q_ok   = (q != 16'd0) && (q <= {9'd0, coil_count});
    q7sum  = {1'b0, q} + 17'd7;
    need   = q7sum[16:3];
    bcr    = need[3:0];
    bc_ok  = {6'd0, bc} == need;
    len_ok = {4'd0, head.fsize} >= 9'd13 + {1'b0, bc};
    qm     = (q[6:0] >= 7'(MAX_COILS)) ? '1 : ((64'd1 << q[6:0]) - 64'd1);
    wmask  = qm << i0[5:0];
    rdata  = (coil_r >> i0[5:0]) & qm;
    bitmap = 64'(b[20:13]);
    wbits  = (bitmap << i0[5:0]) & wmask;
  end

  // function decode
  always_comb begin
    exc   = 1'b0;
    code  = EX_FUNC;
    do_rd = 1'b0;
    do_w5 = 1'b0;
    do_wf = 1'b0;
    unique case (fc)
      FC_READ: begin
        if (head.fsize < 5'd12 || !q_ok) begin
          exc = 1'b1; code = EX_VALUE;
        end else if (!(a_ok && e_ok)) begin
          exc = 1'b1; code = EX_ADDR;
        end else do_rd = 1'b1;
      end
      FC_WSINGLE: begin
        if (head.fsize < 5'd12) begin
          exc = 1'b1; code = EX_VALUE;
        end else if (!a_ok) begin
          exc = 1'b1; code = EX_ADDR;
        end else if (q != COIL_ON && q != 16'h0000) begin
          exc = 1'b1; code = EX_VALUE;
        end else do_w5 = 1'b1;
      end
      FC_WMULTI: begin
        if (head.fsize < 5'd13 || !q_ok || !bc_ok || !len_ok) begin
          exc = 1'b1; code = EX_VALUE;
        end else if (!(a_ok && e_ok)) begin
          exc = 1'b1; code = EX_ADDR;
        end else do_wf = 1'b1;
      end
      default: begin
        exc = 1'b1; code = EX_FUNC;
      end
    endcase
  end

  // response frame assembly
  always_comb begin
    resp    = '0;
    resp[0] = b[0];
    resp[1] = b[1];
    resp[6] = b[6];
    if (exc) begin
      resp[5] = 8'd3;
      resp[7] = fc | EXC_FLAG;
      resp[8] = code;
      resp_n  = 5'd9;
    end else if (do_rd) begin
      resp[5] = 8'd3 + {4'd0, bcr};
      resp[7] = FC_READ;
      resp[8] = {4'd0, bcr};
      for (int k = 0; k < 8; k++) resp[9+k] = rdata[8*k +: 8];
      resp_n  = 5'd9 + {1'b0, bcr};
    end else begin
      resp[5]  = 8'd6;
      resp[7]  = fc;
      resp[8]  = b[8];
      resp[9]  = b[9];
      resp[10] = b[10];
      resp[11] = b[11];
      resp_n   = 5'd12;
    end
  end

  // coil table and output shift line
  always_comb begin
    cmask    = (cnt_wr.count >= 7'(MAX_COILS)) ? '1 : ((64'd1 << cnt_wr.count) - 64'd1);
    coil_nxt = coil_r;
    sh_nxt   = sh_r;
    cnt_nxt  = cnt_r;
    if (taken) begin
      sh_nxt  = sh_r >> 8;
      cnt_nxt = cnt_r - 5'd1;
    end
    if (pop) begin
      sh_nxt  = resp;
      cnt_nxt = resp_n;
      if (do_w5) coil_nxt[i0[5:0]] = (q == COIL_ON);
      if (do_wf) coil_nxt = (coil_r & ~wmask) | wbits;
    end
    if (cnt_wr.en) coil_nxt = coil_nxt & cmask;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 5'd0;
      coil_r <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      coil_r <= coil_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r <= sh_nxt;
  end

  assign out_tvalid = cnt_r != 5'd0;
  assign out_tlast  = cnt_r == 5'd1;
  assign out_tdata  = {coil_r, sh_r[0]};

endmodule

// File: sv/modbus_tcp_coil_server.sv
// Modbus TCP coil server. Takes one request byte per cycle on in_*; a frame
// is complete at 6 + MBAP length bytes, and frames with a nonzero protocol id
// or a foreign unit id are dropped. Served frames go into a two-entry queue;
// the back end answers each with a 9 to 17 byte response, one byte per ready
// cycle from its output shift line, and loads the next request in the cycle
// the last byte is taken. The input stalls only while both queue entries hold
// unanswered frames. out_tdata carries the coil bitmap beside every byte.
// ---------------------------------------------------------------------------
// Modbus TCP coil server top level
// Configuration registers, front end, request queue and back end.
// ---------------------------------------------------------------------------
module modbus_tcp_coil_server import msc_pkg::*; #(
  parameter int RX_LIMIT = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [7:0] tx_byte, [71:8] coil_bits
  output logic        out_tlast,  // tx_last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [7:0]  server_id_r;
  logic [6:0]  coil_count_r, count_clamp;
  logic [15:0] coil_start_r;
  logic        cfg_wr, push, pop, q_full, head_valid;
  job_t        push_job, head;
  cnt_wr_t     cnt_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  // clamp coil count to 1..MAX_COILS
  always_comb begin
    count_clamp = cfg_data[6:0];
    if (count_clamp == 7'd0) count_clamp = 7'd1;
    else if (count_clamp > 7'(MAX_COILS)) count_clamp = 7'(MAX_COILS);
  end

  assign cnt_wr.en    = cfg_wr && (cfg_index == CFG_COIL_COUNT);
  assign cnt_wr.count = count_clamp;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      server_id_r  <= 8'd1;
      coil_count_r <= 7'd8;
      coil_start_r <= 16'd0;
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_SERVER_ID:  server_id_r  <= cfg_data[7:0];
        CFG_COIL_COUNT: coil_count_r <= count_clamp;
        CFG_COIL_START: coil_start_r <= cfg_data;
        default: ;
      endcase
    end
  end

  msc_front #(.RX_LIMIT(RX_LIMIT)) u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .server_id(server_id_r), .q_full, .push, .push_job
  );

  msc_queue u_queue (
    .clk, .rst_n, .push, .push_job, .pop, .full(q_full), .head_valid, .head
  );

  msc_back u_back (
    .clk, .rst_n, .head_valid, .head, .pop,
    .coil_count(coil_count_r), .coil_start(coil_start_r), .cnt_wr,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast
  );

endmodule
